/* rtl/core/tpgoc_pkg.sv */
// Shared types and constants of the two-point gain/offset calibrator.
// Used for the channel payload types, by the divider and by the core; depends on nothing.
package tpgoc_pkg;

   localparam int DATA_W        = 32;
   localparam int DIV_W         = 16;
   localparam int SAMPLE_W      = 12;
   localparam int TARGET_W      = 12;
   localparam int FRACTION_BITS = 12;
   localparam int DIV_STEPS     = DATA_W;
   localparam int STEP_CNT_W    = $clog2(DIV_STEPS);

   localparam logic [TARGET_W-1:0] LOW_TARGET_RESET = 12'h00A;
   localparam logic [TARGET_W-1:0] X_HIGH_RESET     = 12'h276;
   localparam logic [TARGET_W-1:0] Y_HIGH_RESET     = 12'h1D6;

   typedef logic [DATA_W-1:0]   word_type;
   typedef logic [DIV_W-1:0]    divisor_type;
   typedef logic [TARGET_W-1:0] target_type;

   typedef enum logic [1:0] {
      PH_ADD_LOW    = 2'd0,
      PH_FINISH_LOW = 2'd1,
      PH_ADD_HIGH   = 2'd2,
      PH_COMPUTE    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CSR_LOW_TARGET    = 2'd0,
      CSR_X_HIGH_TARGET = 2'd1,
      CSR_Y_HIGH_TARGET = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   typedef struct packed {
      logic [2:0]          req_type;
      logic [SAMPLE_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic     axis_is_y;
      word_type gain;
      word_type offset_magnitude;
      logic     offset_negative;
      logic     divide_error;
   } rsp_payload_type;

   typedef struct packed {
      csr_index_type index;
      target_type    data;
   } csr_payload_type;

endpackage

/* rtl/core/tpgoc_stream_if.sv */
// Valid/ready channel carrying one payload of a type given per instance.
// Payload types come from tpgoc_pkg.
interface tpgoc_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/tpgoc_divider.sv */
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 16-bit divisor.
// Depends on tpgoc_pkg for widths.
module tpgoc_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tpgoc_pkg::word_type    dividend,
   input  tpgoc_pkg::divisor_type divisor,
   output logic                  done,
   output tpgoc_pkg::word_type    quotient
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [tpgoc_pkg::STEP_CNT_W-1:0]    cnt_ff, cnt_in;
   tpgoc_pkg::word_type                 quo_ff, quo_in;
   tpgoc_pkg::divisor_type              rem_ff, rem_in;
   tpgoc_pkg::divisor_type              den_ff, den_in;

   logic [tpgoc_pkg::DIV_W:0]           trial;
   logic [tpgoc_pkg::DIV_W:0]           trial_diff;
   logic                                fits;

   // shift the next dividend bit into the partial remainder, try to subtract
   assign trial      = {rem_ff, quo_ff[tpgoc_pkg::DATA_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign fits       = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial_diff[tpgoc_pkg::DIV_W-1:0] : trial[tpgoc_pkg::DIV_W-1:0];
         quo_in = {quo_ff[tpgoc_pkg::DATA_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tpgoc_pkg::STEP_CNT_W'(tpgoc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/two_point_gain_offset_calibrator_core.sv */
// Two-point gain/offset calibrator core: top level. Depends on tpgoc_pkg,
// tpgoc_stream_if and tpgoc_divider.
//
// Calibration samples arrive on req_chan, each tagged with a phase code in
// req_type (bit 2 picks the axis, bits 1..0: add low, finish low, add high,
// finish and compute). The three accumulate phases leave the block idle, and a
// new transfer may follow in the next cycle. The compute phase halves the
// high-point sum, divides ((high_target - low_target) << 12) by the 16-bit
// read difference, multiplies the halved high sum by the gain and forms the
// signed offset; it occupies the block until its result is loaded, mostly
// in the 32-step restoring divider (one quotient bit per cycle), and
// req_chan.ready stays low meanwhile. A zero read difference skips the divider.
// Exactly one result leaves on rsp_chan
// per compute; it sits in an output register, so the next calibration run
// can start while the result waits, and a later compute holds only if the
// previous result has not been taken yet. A zero read difference gives
// gain 0 with divide_error set; the offset is still formed. All sums clear
// after each compute. Target registers are written on csr_chan, which is
// always ready; write them only while the block is idle.
module two_point_gain_offset_calibrator_core (
   input  logic            clock,
   input  logic            reset,
   tpgoc_stream_if.sink    req_chan,
   tpgoc_stream_if.source  rsp_chan,
   tpgoc_stream_if.sink    csr_chan
);

   // control state
   tpgoc_pkg::state_type         state_ff, state_in;
   logic                         taken_ff, taken_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // configuration registers
   tpgoc_pkg::target_type        low_tgt_ff, low_tgt_in;
   tpgoc_pkg::target_type        x_high_ff, x_high_in;
   tpgoc_pkg::target_type        y_high_ff, y_high_in;

   // accumulators
   tpgoc_pkg::word_type          low_sum_ff, low_sum_in;
   tpgoc_pkg::word_type          high_sum_ff, high_sum_in;

   // per-compute working registers
   logic                         axis_ff, axis_in;
   tpgoc_pkg::target_type        hi_t_ff, hi_t_in;
   tpgoc_pkg::target_type        lo_t_ff, lo_t_in;
   tpgoc_pkg::word_type          gain_ff, gain_in;
   logic                         err_ff, err_in;
   tpgoc_pkg::word_type          prod_ff, prod_in;
   tpgoc_pkg::rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic                         req_xfer;
   logic                         rsp_xfer;
   logic                         out_load;
   tpgoc_pkg::phase_type         phase;
   tpgoc_pkg::word_type          low_add;
   tpgoc_pkg::word_type          high_add;
   tpgoc_pkg::word_type          numer;
   tpgoc_pkg::divisor_type       denom;
   tpgoc_pkg::word_type          target_scaled;
   logic                         div_start;
   logic                         div_done;
   tpgoc_pkg::word_type          div_quotient;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;
   assign phase    = tpgoc_pkg::phase_type'(req_chan.payload.req_type[1:0]);

   assign low_add  = low_sum_ff + tpgoc_pkg::word_type'(req_chan.payload.sample);
   assign high_add = high_sum_ff + tpgoc_pkg::word_type'(req_chan.payload.sample);

   // divider operands: target span in fixed point over the wrapped read span
   assign numer = (tpgoc_pkg::word_type'(hi_t_ff) - tpgoc_pkg::word_type'(lo_t_ff))
                  << tpgoc_pkg::FRACTION_BITS;
   assign denom = high_sum_ff[tpgoc_pkg::DIV_W-1:0] - low_sum_ff[tpgoc_pkg::DIV_W-1:0];
   assign target_scaled = tpgoc_pkg::word_type'(hi_t_ff) << tpgoc_pkg::FRACTION_BITS;

   assign req_chan.ready = (state_ff == tpgoc_pkg::ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   tpgoc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numer),
      .divisor  (denom),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // configuration writes; unknown indexes drop
   always_comb begin
      low_tgt_in = low_tgt_ff;
      x_high_in  = x_high_ff;
      y_high_in  = y_high_ff;
      if (csr_chan.valid) begin
         case (csr_chan.payload.index)
            tpgoc_pkg::CSR_LOW_TARGET:    low_tgt_in = csr_chan.payload.data;
            tpgoc_pkg::CSR_X_HIGH_TARGET: x_high_in  = csr_chan.payload.data;
            tpgoc_pkg::CSR_Y_HIGH_TARGET: y_high_in  = csr_chan.payload.data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      taken_in    = taken_ff;
      low_sum_in  = low_sum_ff;
      high_sum_in = high_sum_ff;
      axis_in     = axis_ff;
      hi_t_in     = hi_t_ff;
      lo_t_in     = lo_t_ff;
      gain_in     = gain_ff;
      err_in      = err_ff;
      prod_in     = prod_ff;
      rsp_data_in = rsp_data_ff;
      div_start   = 1'b0;
      out_load    = 1'b0;

      case (state_ff)
         tpgoc_pkg::ST_IDLE: begin
            if (req_xfer) begin
               case (phase)
                  tpgoc_pkg::PH_ADD_LOW: begin
                     low_sum_in = low_add;
                  end
                  tpgoc_pkg::PH_FINISH_LOW: begin
                     low_sum_in = {1'b0, low_add[tpgoc_pkg::DATA_W-1:1]};
                     taken_in   = 1'b1;
                  end
                  tpgoc_pkg::PH_ADD_HIGH: begin
                     high_sum_in = high_add;
                  end
                  tpgoc_pkg::PH_COMPUTE: begin
                     // halve the high sum, latch targets for this run
                     high_sum_in = {1'b0, high_add[tpgoc_pkg::DATA_W-1:1]};
                     axis_in     = req_chan.payload.req_type[2];
                     hi_t_in     = req_chan.payload.req_type[2] ? y_high_ff : x_high_ff;
                     lo_t_in     = taken_ff ? low_tgt_ff : '0;
                     state_in    = tpgoc_pkg::ST_PREP;
                  end
                  default: ;
               endcase
            end
         end
         tpgoc_pkg::ST_PREP: begin
            if (denom == '0) begin
               gain_in  = '0;
               err_in   = 1'b1;
               state_in = tpgoc_pkg::ST_MUL;
            end else begin
               div_start = 1'b1;
               err_in    = 1'b0;
               state_in  = tpgoc_pkg::ST_DIV;
            end
         end
         tpgoc_pkg::ST_DIV: begin
            if (div_done) begin
               gain_in  = div_quotient;
               state_in = tpgoc_pkg::ST_MUL;
            end
         end
         tpgoc_pkg::ST_MUL: begin
            // low 32 bits of the product only
            prod_in  = tpgoc_pkg::DATA_W'(high_sum_ff * gain_ff);
            state_in = tpgoc_pkg::ST_FIN;
         end
         tpgoc_pkg::ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load                     = 1'b1;
               rsp_data_in.axis_is_y        = axis_ff;
               rsp_data_in.gain             = gain_ff;
               rsp_data_in.divide_error     = err_ff;
               rsp_data_in.offset_negative  = (target_scaled < prod_ff);
               rsp_data_in.offset_magnitude = (target_scaled < prod_ff)
                                              ? (prod_ff - target_scaled)
                                              : (target_scaled - prod_ff);
               low_sum_in  = '0;
               high_sum_in = '0;
               taken_in    = 1'b0;
               state_in    = tpgoc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpgoc_pkg::ST_IDLE;
         end
      endcase
   end

   // output register: load wins over a same-cycle transfer of the old result
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpgoc_pkg::ST_IDLE;
         taken_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         low_tgt_ff   <= tpgoc_pkg::LOW_TARGET_RESET;
         x_high_ff    <= tpgoc_pkg::X_HIGH_RESET;
         y_high_ff    <= tpgoc_pkg::Y_HIGH_RESET;
         low_sum_ff   <= '0;
         high_sum_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
         low_tgt_ff   <= low_tgt_in;
         x_high_ff    <= x_high_in;
         y_high_ff    <= y_high_in;
         low_sum_ff   <= low_sum_in;
         high_sum_ff  <= high_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      hi_t_ff     <= hi_t_in;
      lo_t_ff     <= lo_t_in;
      gain_ff     <= gain_in;
      err_ff      <= err_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a flagged divide error always carries a zero gain
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.divide_error |-> rsp_data_ff.gain == '0)
      else $error("divide error with nonzero gain");

   // the divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == tpgoc_pkg::ST_DIV)
      else $error("divider done outside divide state");

   // loading a result clears all sums
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> low_sum_ff == '0 && high_sum_ff == '0 && !taken_ff && rsp_valid_ff)
      else $error("sums not cleared after compute");

   // a new compute starts only from an idle sequencer
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> $past(state_ff) == tpgoc_pkg::ST_IDLE && state_ff == tpgoc_pkg::ST_PREP)
      else $error("divider started out of sequence");

endmodule
